### hw/rtl/mtbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtbm_pkg
// Shared sizes, codes and arithmetic helpers of the tanh network engine.
// ----------------------------------------------------------------------------
package mtbm_pkg;

    localparam int NUM_LAYERS  = 3;
    localparam int INPUT_SIZE  = 64;
    localparam int HIDDEN_SIZE = 32;
    localparam int OUTPUT_SIZE = 4;

    localparam int W_DEPTH = (NUM_LAYERS == 2) ? (INPUT_SIZE + 1) * OUTPUT_SIZE :
        (INPUT_SIZE + 1) * HIDDEN_SIZE + (NUM_LAYERS - 3) * (HIDDEN_SIZE + 1) * HIDDEN_SIZE
        + (HIDDEN_SIZE + 1) * OUTPUT_SIZE;
    localparam int A_DEPTH = INPUT_SIZE + 1 + (NUM_LAYERS - 2) * (HIDDEN_SIZE + 1)
        + OUTPUT_SIZE;
    localparam int E_DEPTH = (NUM_LAYERS - 2) * HIDDEN_SIZE + OUTPUT_SIZE;
    localparam int T_DEPTH = OUTPUT_SIZE;

    localparam int WAW = $clog2(W_DEPTH);
    localparam int AAW = $clog2(A_DEPTH);
    localparam int EAW = (E_DEPTH > 1) ? $clog2(E_DEPTH) : 1;
    localparam int TAW = (T_DEPTH > 1) ? $clog2(T_DEPTH) : 1;
    localparam int CW  = 12;  // loop counter width, covers any layer size + 1
    localparam int ACCW = 48;

    localparam logic [2:0] KIND_WR_W  = 3'd0;
    localparam logic [2:0] KIND_RD_W  = 3'd1;
    localparam logic [2:0] KIND_WR_F  = 3'd2;
    localparam logic [2:0] KIND_WR_T  = 3'd3;
    localparam logic [2:0] KIND_FWD   = 3'd4;
    localparam logic [2:0] KIND_TRAIN = 3'd5;

    localparam logic [1:0] RES_WEIGHT = 2'd0;
    localparam logic [1:0] RES_ACT    = 2'd1;
    localparam logic [1:0] RES_DONE   = 2'd2;

    localparam logic [1:0] CFG_RATE  = 2'd0;
    localparam logic [1:0] CFG_MOM   = 2'd1;
    localparam logic [1:0] CFG_DECAY = 2'd2;

    localparam logic signed [15:0] ONE_Q = 16'sd4096;

    function automatic int lsize(input int l);
        if (l == 0) return INPUT_SIZE;
        if (l == NUM_LAYERS - 1) return OUTPUT_SIZE;
        return HIDDEN_SIZE;
    endfunction

    function automatic int act_base(input int l);
        int b;
        b = 0;
        for (int k = 0; k < NUM_LAYERS; k++) if (k < l) b += lsize(k) + 1;
        return b;
    endfunction

    function automatic int w_base(input int l);
        int b;
        b = 0;
        for (int k = 0; k < NUM_LAYERS - 1; k++)
            if (k < l) b += (lsize(k) + 1) * lsize(k + 1);
        return b;
    endfunction

    function automatic int e_base(input int l);
        int b;
        b = 0;
        for (int k = 1; k < NUM_LAYERS; k++) if (k < l) b += lsize(k);
        return b;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [ACCW-1:0] v);
        if (v > 48'sd32767) return 16'sd32767;
        if (v < -48'sd32768) return -16'sd32768;
        return v[15:0];
    endfunction

    // round to nearest, ties away from zero
    function automatic logic signed [ACCW-1:0] rnd_shift(input logic signed [ACCW-1:0] p,
                                                         input logic sh16);
        logic [ACCW-1:0] m;
        logic [ACCW-1:0] r;
        m = p[ACCW-1] ? ACCW'(-p) : ACCW'(p);
        if (sh16) r = (m + ACCW'(32768)) >> 16;
        else      r = (m + ACCW'(2048)) >> 12;
        return p[ACCW-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [12:0] tanh_pt(input logic [4:0] i);
        logic [12:0] y;
        case (i)
            5'd0:  y = 13'd0;    5'd1:  y = 13'd1003; 5'd2:  y = 13'd1893;
            5'd3:  y = 13'd2602; 5'd4:  y = 13'd3119; 5'd5:  y = 13'd3475;
            5'd6:  y = 13'd3707; 5'd7:  y = 13'd3856; 5'd8:  y = 13'd3949;
            5'd9:  y = 13'd4006; 5'd10: y = 13'd4041; 5'd11: y = 13'd4063;
            5'd12: y = 13'd4076; 5'd13: y = 13'd4084; 5'd14: y = 13'd4089;
            5'd15: y = 13'd4091; 5'd16: y = 13'd4093; 5'd17: y = 13'd4094;
            5'd18: y = 13'd4095; 5'd19: y = 13'd4095; 5'd20: y = 13'd4096;
            default: y = 13'd4096;
        endcase
        return y;
    endfunction

    function automatic logic signed [15:0] tanh_q(input logic signed [15:0] x);
        logic [16:0] ax;
        logic [4:0] i;
        logic [9:0] f;
        logic [12:0] y0;
        logic [12:0] y1;
        logic [23:0] p;
        logic [12:0] y;
        ax = x[15] ? 17'(-$signed({x[15], x})) : 17'({1'b0, x});
        i = ax[14:10];
        f = ax[9:0];
        y0 = tanh_pt(i);
        y1 = tanh_pt(i + 5'd1);
        p = 24'((y1 - y0)) * 24'(f) + 24'd512;
        y = (ax >= 17'd20480) ? 13'd4096 : y0 + 13'(p >> 10);
        return x[15] ? -$signed({3'b000, y}) : $signed({3'b000, y});
    endfunction

endpackage

### hw/rtl/mtbm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtbm_in_if / mtbm_out_if / mtbm_cfg_if
// Valid/ready channels of the network engine.
// ----------------------------------------------------------------------------
interface mtbm_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic [2:0]        layer_index;
    logic [6:0]        row_index;
    logic [5:0]        column_index;
    logic signed [15:0] data_value;
    modport source (output valid, kind, layer_index, row_index, column_index, data_value,
                    input ready);
    modport sink (input valid, kind, layer_index, row_index, column_index, data_value,
                  output ready);
endinterface

interface mtbm_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        result_kind;
    logic signed [15:0] result_value;
    logic [5:0]        result_index;
    logic              last_result;
    modport source (output valid, result_kind, result_value, result_index, last_result,
                    input ready);
    modport sink (input valid, result_kind, result_value, result_index, last_result,
                  output ready);
endinterface

interface mtbm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/mtbm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtbm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mtbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

### hw/rtl/mlp_tanh_backprop_momentum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_tanh_backprop_momentum
// Tanh network engine: weight load/read, forward pass, momentum training.
// ----------------------------------------------------------------------------
// Usage: items enter on in (valid/ready), results leave on out, registers
// are written on cfg (index 0 rate, 1 momentum, 2 decay). One item is
// worked on at a time; in.ready is low while an item runs. A result that
// waits in the output register does not block the next item.
// A write is taken while idle. A weight read goes through S_RDW and
// S_RDW2 to the output register. A forward pass runs S_FA, S_FB, S_FC
// per weight (single read port of the weight RAM, one multiply-accumulate
// per weight) and S_FW per unit, then S_FO, S_FO2 per output transaction.
// A training step runs S_OA, S_OB, S_OC per output error, S_HA to S_HC per
// weight and S_HD to S_HF per unit for hidden errors and S_UA, S_UB, S_UC,
// S_UE per weight for the update (read weight and previous change, write
// both), ending in one done transaction. After reset a clearing pass over
// all W_DEPTH (2212) addresses zeroes the previous-change memory and
// writes the bias activations; no item is accepted meanwhile. A stalled
// receiver holds the result register and the engine waits with its next
// result; nothing is dropped.
// ----------------------------------------------------------------------------
module mlp_tanh_backprop_momentum (
    input logic       clk,
    input logic       rst_n,
    mtbm_in_if.sink   in,
    mtbm_out_if.source out,
    mtbm_cfg_if.sink  cfg
);
    localparam int WAW = mtbm_pkg::WAW;
    localparam int AAW = mtbm_pkg::AAW;
    localparam int EAW = mtbm_pkg::EAW;
    localparam int TAW = mtbm_pkg::TAW;
    localparam int CW  = mtbm_pkg::CW;
    localparam int ACCW = mtbm_pkg::ACCW;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_RDW   = 5'd2;
    localparam logic [4:0] S_RDW2  = 5'd3;
    localparam logic [4:0] S_OUT   = 5'd4;
    localparam logic [4:0] S_FA    = 5'd5;   // forward: issue weight read
    localparam logic [4:0] S_FB    = 5'd6;   // issue activation read
    localparam logic [4:0] S_FC    = 5'd7;   // accumulate
    localparam logic [4:0] S_FW    = 5'd8;   // write activation
    localparam logic [4:0] S_FO    = 5'd9;   // read output activation
    localparam logic [4:0] S_FO2   = 5'd10;
    localparam logic [4:0] S_OA    = 5'd11;  // output error: read act
    localparam logic [4:0] S_OB    = 5'd12;  // read target
    localparam logic [4:0] S_OC    = 5'd13;  // write error
    localparam logic [4:0] S_HA    = 5'd14;  // hidden error: weight read
    localparam logic [4:0] S_HB    = 5'd15;  // error read
    localparam logic [4:0] S_HC    = 5'd16;  // accumulate
    localparam logic [4:0] S_HD    = 5'd17;  // act read for derivative
    localparam logic [4:0] S_HE    = 5'd18;
    localparam logic [4:0] S_HF    = 5'd19;  // write error
    localparam logic [4:0] S_UA    = 5'd20;  // update: read w and prev
    localparam logic [4:0] S_UB    = 5'd21;  // read act
    localparam logic [4:0] S_UC    = 5'd22;  // read error, gradient
    localparam logic [4:0] S_UE    = 5'd24;  // change, write back
    localparam logic [4:0] S_DONE  = 5'd25;

    logic [4:0] state_reg, state_next;

    // memory ports
    logic w_we, p_we, a_we, e_we, t_we;
    logic [WAW-1:0] w_addr, p_addr;
    logic [AAW-1:0] a_addr;
    logic [EAW-1:0] e_addr;
    logic [TAW-1:0] t_addr;
    logic [15:0] w_wd, p_wd, a_wd, e_wd, t_wd;
    logic [15:0] w_rd, p_rd, a_rd, e_rd, t_rd;

    mtbm_ram #(.WIDTH(16), .DEPTH(mtbm_pkg::W_DEPTH)) u_w (.clk(clk), .we(w_we),
        .addr(w_addr), .wdata(w_wd), .rdata(w_rd));
    mtbm_ram #(.WIDTH(16), .DEPTH(mtbm_pkg::W_DEPTH)) u_p (.clk(clk), .we(p_we),
        .addr(p_addr), .wdata(p_wd), .rdata(p_rd));
    mtbm_ram #(.WIDTH(16), .DEPTH(mtbm_pkg::A_DEPTH)) u_a (.clk(clk), .we(a_we),
        .addr(a_addr), .wdata(a_wd), .rdata(a_rd));
    mtbm_ram #(.WIDTH(16), .DEPTH(mtbm_pkg::E_DEPTH)) u_e (.clk(clk), .we(e_we),
        .addr(e_addr), .wdata(e_wd), .rdata(e_rd));
    mtbm_ram #(.WIDTH(16), .DEPTH(mtbm_pkg::T_DEPTH)) u_t (.clk(clk), .we(t_we),
        .addr(t_addr), .wdata(t_wd), .rdata(t_rd));

    logic [15:0] rate_reg, mom_reg, decay_reg;

    logic [2:0]  lay_reg, lay_next;
    logic [CW-1:0] r_reg, r_next, j_reg, j_next;
    logic [15:0] val_reg;
    logic [WAW-1:0] widx_reg;
    logic wok_reg;
    logic signed [ACCW-1:0] acc_reg, acc_next;
    logic signed [15:0] x_reg, x_next, y_reg, y_next, g_reg, g_next, pv_reg, pv_next;
    logic [15:0] ov_reg, ov_next;
    logic [1:0] ok_reg, ok_next;
    logic [5:0] oi_reg, oi_next;
    logic ol_reg, ol_next, ovld_reg, ovld_next;
    logic [WAW-1:0] clr_reg;

    // per-layer geometry for the current layer
    logic [CW-1:0] rows_c, cols_c, nsz_c;
    logic [WAW-1:0] wb_c;
    logic [AAW-1:0] ab_c, an_c;
    logic [EAW-1:0] eb_c, en_c;

    always_comb
    begin
        rows_c = '0; cols_c = '0; nsz_c = '0; wb_c = '0; ab_c = '0; an_c = '0;
        eb_c = '0; en_c = '0;
        for (int l = 0; l < mtbm_pkg::NUM_LAYERS; l++)
        begin
            if (3'(l) == lay_reg)
            begin
                nsz_c = CW'(mtbm_pkg::lsize(l));
                rows_c = CW'(mtbm_pkg::lsize(l) + 1);
                cols_c = CW'(mtbm_pkg::lsize((l + 1 < mtbm_pkg::NUM_LAYERS) ? l + 1 : l));
                wb_c = WAW'(mtbm_pkg::w_base(l));
                ab_c = AAW'(mtbm_pkg::act_base(l));
                an_c = AAW'(mtbm_pkg::act_base(l + 1));
                eb_c = EAW'(mtbm_pkg::e_base(l));
                en_c = EAW'(mtbm_pkg::e_base(l + 1));
            end
        end
    end

    // input address decode
    logic in_wok;
    logic [WAW-1:0] in_widx;
    always_comb
    begin
        in_wok = 1'b0;
        in_widx = '0;
        for (int l = 0; l < mtbm_pkg::NUM_LAYERS - 1; l++)
        begin
            if (3'(l) == in.layer_index && 32'(in.row_index) <= mtbm_pkg::lsize(l)
                && 32'(in.column_index) < mtbm_pkg::lsize(l + 1))
            begin
                in_wok = 1'b1;
                in_widx = WAW'(mtbm_pkg::w_base(l)
                    + 32'(in.row_index) * mtbm_pkg::lsize(l + 1) + 32'(in.column_index));
            end
        end
    end

    logic is_bias_a;
    always_comb
    begin
        is_bias_a = 1'b0;
        for (int l = 0; l < mtbm_pkg::NUM_LAYERS - 1; l++)
            if (clr_reg == WAW'(mtbm_pkg::act_base(l) + mtbm_pkg::lsize(l)))
                is_bias_a = 1'b1;
    end

    assign in.ready  = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out.valid = ovld_reg;
    assign out.result_kind  = ok_reg;
    assign out.result_value = ov_reg;
    assign out.result_index = oi_reg;
    assign out.last_result  = ol_reg;

    logic in_acc;
    assign in_acc = in.valid && in.ready;

    // multiplier and derived terms, one product per cycle
    logic signed [ACCW-1:0] prod_ww;   // Q3.12 x Q3.12 of memory data
    logic signed [15:0] q_ae, f_dec, f_rate, f_mom, ch_c, d_c, he_c;
    logic sum_row_is_bias;
    assign prod_ww = ACCW'(32'($signed(w_rd))
                     * 32'($signed(state_reg == S_FC ? a_rd : e_rd)));

    always_comb
    begin
        q_ae   = mtbm_pkg::sat16(mtbm_pkg::rnd_shift(ACCW'(32'(x_reg) * 32'($signed(e_rd))),
                 1'b0));
        f_dec  = mtbm_pkg::sat16(mtbm_pkg::rnd_shift(ACCW'(32'($signed({1'b0, decay_reg}))
                 * 32'(y_reg)), 1'b1));
        f_rate = mtbm_pkg::sat16(mtbm_pkg::rnd_shift(ACCW'(32'($signed({1'b0, rate_reg}))
                 * 32'(g_reg)), 1'b1));
        f_mom  = mtbm_pkg::sat16(mtbm_pkg::rnd_shift(ACCW'(32'($signed({1'b0, mom_reg}))
                 * 32'(pv_reg)), 1'b1));
        ch_c   = mtbm_pkg::sat16(ACCW'(f_mom) - ACCW'(f_rate));
        d_c    = mtbm_pkg::sat16(ACCW'(mtbm_pkg::ONE_Q) - ACCW'(mtbm_pkg::sat16(
                 mtbm_pkg::rnd_shift(ACCW'(32'($signed(a_rd)) * 32'($signed(a_rd))), 1'b0))));
        he_c   = mtbm_pkg::sat16(mtbm_pkg::rnd_shift(ACCW'(32'(x_reg) * 32'(y_reg)), 1'b0));
        sum_row_is_bias = (r_reg == nsz_c);
    end

    logic signed [15:0] acc_rnd;
    assign acc_rnd = mtbm_pkg::sat16(mtbm_pkg::rnd_shift(acc_reg, 1'b0));

    logic [WAW-1:0] widx_c;
    assign widx_c = wb_c + WAW'(r_reg * cols_c + j_reg);

    always_comb
    begin
        state_next = state_reg;
        lay_next = lay_reg; r_next = r_reg; j_next = j_reg; acc_next = acc_reg;
        x_next = x_reg; y_next = y_reg; g_next = g_reg; pv_next = pv_reg;
        ov_next = ov_reg; ok_next = ok_reg; oi_next = oi_reg; ol_next = ol_reg;
        ovld_next = ovld_reg && !out.ready;
        w_we = 1'b0; p_we = 1'b0; a_we = 1'b0; e_we = 1'b0; t_we = 1'b0;
        w_addr = widx_c; p_addr = widx_c; a_addr = '0; e_addr = '0; t_addr = '0;
        w_wd = val_reg; p_wd = '0; a_wd = val_reg; e_wd = '0; t_wd = val_reg;
        case (state_reg)
            S_CLR:
            begin
                p_we = 1'b1; p_addr = clr_reg;
                if ({{(32-WAW){1'b0}}, clr_reg} < 32'(mtbm_pkg::A_DEPTH) && is_bias_a)
                begin
                    a_we = 1'b1; a_addr = AAW'(clr_reg); a_wd = mtbm_pkg::ONE_Q;
                end
                if (clr_reg == WAW'(mtbm_pkg::W_DEPTH - 1)) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (in.kind)
                        mtbm_pkg::KIND_WR_W:
                        begin
                            w_we = in_wok; w_addr = in_widx; w_wd = in.data_value;
                        end
                        mtbm_pkg::KIND_RD_W:
                        begin
                            w_addr = in_widx; state_next = S_RDW;
                        end
                        mtbm_pkg::KIND_WR_F:
                        begin
                            a_we = 32'(in.column_index) < mtbm_pkg::INPUT_SIZE;
                            a_addr = AAW'(in.column_index); a_wd = in.data_value;
                        end
                        mtbm_pkg::KIND_WR_T:
                        begin
                            t_we = 32'(in.column_index) < mtbm_pkg::OUTPUT_SIZE;
                            t_addr = TAW'(in.column_index); t_wd = in.data_value;
                        end
                        mtbm_pkg::KIND_FWD:
                        begin
                            lay_next = '0; r_next = '0; j_next = '0; acc_next = '0;
                            state_next = S_FA;
                        end
                        mtbm_pkg::KIND_TRAIN:
                        begin
                            j_next = '0; state_next = S_OA;
                        end
                        default: ;
                    endcase
                end
            end
            S_RDW:
            begin
                w_addr = widx_reg; state_next = S_RDW2;
            end
            S_RDW2:
            begin
                // hold the address so the read data stays valid while stalled
                w_addr = widx_reg;
                if (!ovld_reg || out.ready)
                begin
                    ovld_next = 1'b1; ok_next = mtbm_pkg::RES_WEIGHT;
                    ov_next = wok_reg ? w_rd : 16'd0; oi_next = '0; ol_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // forward
            S_FA:
            begin
                w_addr = widx_c; a_addr = ab_c + AAW'(r_reg); state_next = S_FB;
            end
            S_FB:
            begin
                w_addr = widx_c; a_addr = ab_c + AAW'(r_reg); state_next = S_FC;
            end
            S_FC:
            begin
                acc_next = acc_reg + prod_ww;
                if (r_reg == rows_c - 1'b1) state_next = S_FW;
                else
                begin
                    r_next = r_reg + 1'b1; state_next = S_FA;
                end
            end
            S_FW:
            begin
                a_we = 1'b1; a_addr = an_c + AAW'(j_reg);
                a_wd = mtbm_pkg::tanh_q(acc_rnd);
                acc_next = '0; r_next = '0;
                if (j_reg == cols_c - 1'b1)
                begin
                    j_next = '0;
                    if (32'(lay_reg) == mtbm_pkg::NUM_LAYERS - 2) state_next = S_FO;
                    else
                    begin
                        lay_next = lay_reg + 1'b1; state_next = S_FA;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1; state_next = S_FA;
                end
            end
            S_FO:
            begin
                a_addr = AAW'(mtbm_pkg::act_base(mtbm_pkg::NUM_LAYERS - 1)) + AAW'(j_reg);
                state_next = S_FO2;
            end
            S_FO2:
            begin
                a_addr = AAW'(mtbm_pkg::act_base(mtbm_pkg::NUM_LAYERS - 1)) + AAW'(j_reg);
                if (!ovld_reg || out.ready)
                begin
                    ovld_next = 1'b1; ok_next = mtbm_pkg::RES_ACT; ov_next = a_rd;
                    oi_next = 6'(j_reg);
                    ol_next = (32'(j_reg) == mtbm_pkg::OUTPUT_SIZE - 1);
                    if (32'(j_reg) == mtbm_pkg::OUTPUT_SIZE - 1) state_next = S_IDLE;
                    else
                    begin
                        j_next = j_reg + 1'b1; state_next = S_FO;
                    end
                end
            end
            // output error
            S_OA:
            begin
                a_addr = AAW'(mtbm_pkg::act_base(mtbm_pkg::NUM_LAYERS - 1)) + AAW'(j_reg);
                t_addr = TAW'(j_reg); state_next = S_OB;
            end
            S_OB:
            begin
                x_next = a_rd; y_next = t_rd; state_next = S_OC;
            end
            S_OC:
            begin
                e_we = 1'b1;
                e_addr = EAW'(mtbm_pkg::e_base(mtbm_pkg::NUM_LAYERS - 1)) + EAW'(j_reg);
                e_wd = mtbm_pkg::sat16(ACCW'(x_reg) - ACCW'(y_reg));
                if (32'(j_reg) == mtbm_pkg::OUTPUT_SIZE - 1)
                begin
                    j_next = '0; r_next = '0; acc_next = '0;
                    if (mtbm_pkg::NUM_LAYERS > 2)
                    begin
                        lay_next = 3'(mtbm_pkg::NUM_LAYERS - 2); state_next = S_HA;
                    end
                    else
                    begin
                        lay_next = '0; state_next = S_UA;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1; state_next = S_OA;
                end
            end
            // hidden error for layer lay_reg, rows r, over next layer cols j
            S_HA:
            begin
                w_addr = widx_c; e_addr = en_c + EAW'(j_reg); state_next = S_HB;
            end
            S_HB:
            begin
                w_addr = widx_c; e_addr = en_c + EAW'(j_reg); state_next = S_HC;
            end
            S_HC:
            begin
                acc_next = acc_reg + prod_ww;
                if (j_reg == cols_c - 1'b1) state_next = S_HD;
                else
                begin
                    j_next = j_reg + 1'b1; state_next = S_HA;
                end
            end
            S_HD:
            begin
                a_addr = ab_c + AAW'(r_reg); x_next = acc_rnd; state_next = S_HE;
            end
            S_HE:
            begin
                y_next = d_c; state_next = S_HF;
            end
            S_HF:
            begin
                e_we = 1'b1; e_addr = eb_c + EAW'(r_reg); e_wd = he_c;
                acc_next = '0; j_next = '0;
                if (r_reg == nsz_c - 1'b1)
                begin
                    r_next = '0;
                    if (lay_reg == 3'd1)
                    begin
                        lay_next = '0; state_next = S_UA;
                    end
                    else
                    begin
                        lay_next = lay_reg - 1'b1; state_next = S_HA;
                    end
                end
                else
                begin
                    r_next = r_reg + 1'b1; state_next = S_HA;
                end
            end
            // weight update
            S_UA:
            begin
                w_addr = widx_c; p_addr = widx_c; a_addr = ab_c + AAW'(r_reg);
                e_addr = en_c + EAW'(j_reg); state_next = S_UB;
            end
            S_UB:
            begin
                y_next = w_rd; pv_next = p_rd; x_next = a_rd; state_next = S_UC;
                e_addr = en_c + EAW'(j_reg);
            end
            S_UC:
            begin
                e_addr = en_c + EAW'(j_reg);
                g_next = sum_row_is_bias ? q_ae
                         : mtbm_pkg::sat16(ACCW'(q_ae) + ACCW'(f_dec));
                state_next = S_UE;
            end
            S_UE:
            begin
                w_we = 1'b1; p_we = 1'b1;
                w_wd = mtbm_pkg::sat16(ACCW'(y_reg) + ACCW'(ch_c)); p_wd = ch_c;
                if (j_reg == cols_c - 1'b1)
                begin
                    j_next = '0;
                    if (r_reg == rows_c - 1'b1)
                    begin
                        r_next = '0;
                        if (32'(lay_reg) == mtbm_pkg::NUM_LAYERS - 2) state_next = S_DONE;
                        else
                        begin
                            lay_next = lay_reg + 1'b1; state_next = S_UA;
                        end
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1; state_next = S_UA;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1; state_next = S_UA;
                end
            end
            S_DONE:
            begin
                if (!ovld_reg || out.ready)
                begin
                    ovld_next = 1'b1; ok_next = mtbm_pkg::RES_DONE; ov_next = '0;
                    oi_next = '0; ol_next = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            ovld_reg <= 1'b0;
            rate_reg <= '0;
            mom_reg <= '0;
            decay_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ovld_reg <= ovld_next;
            if (state_reg == S_CLR) clr_reg <= clr_reg + 1'b1;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    mtbm_pkg::CFG_RATE:  rate_reg <= cfg.data;
                    mtbm_pkg::CFG_MOM:   mom_reg <= cfg.data;
                    mtbm_pkg::CFG_DECAY: decay_reg <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lay_reg <= lay_next; r_reg <= r_next; j_reg <= j_next; acc_reg <= acc_next;
        x_reg <= x_next; y_reg <= y_next; g_reg <= g_next; pv_reg <= pv_next;
        ov_reg <= ov_next; ok_reg <= ok_next; oi_reg <= oi_next; ol_reg <= ol_next;
        if (in_acc)
        begin
            val_reg <= in.data_value;
            widx_reg <= in_widx; wok_reg <= in_wok;
        end
    end
endmodule
